[hdl/deq_pkg.sv]
// types and codes shared by the double-ended queue controller and datapath
// no dependencies
package deq_pkg;

    typedef enum logic [2:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_PEEK       = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic peek;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/deq_ctrl.sv]
// sequencing state machine for the double-ended queue
// depends on deq_pkg
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  deq_pkg::t_dp_sts  i_sts,
    output logic              o_stall,
    output deq_pkg::t_dp_cmd  o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_PEEK;
            S_PEEK: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_EXEC: o_cmd.exec = 1'b1;
            S_PEEK: o_cmd.peek = 1'b1;
            S_DONE: o_cmd.load_out = i_sts.out_free;
            default: o_stall = 1'b1;
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.exec, o_cmd.peek, o_cmd.load_out}))
        else $error("more than one datapath command");

    a_exec_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec ##1 o_cmd.peek)
        else $error("load not followed by exec and peek");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec || o_cmd.peek) |-> o_stall)
        else $error("input open while an item is in flight");

endmodule

[hdl/deq_dp.sv]
// datapath of the double-ended queue: circular word memory, head and count,
// result register; depends on deq_pkg
module deq_dp #(
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  deq_pkg::t_dp_cmd                      i_cmd,
    output deq_pkg::t_dp_sts                      o_sts,
    input  logic [2:0]                            i_kind,
    input  logic signed [31:0]                    i_value,
    input  logic                                  i_stall,
    output logic                                  o_valid,
    output logic signed [31:0]                    o_popped_value,
    output deq_pkg::t_status                      o_status,
    output logic [$clog2(DEPTH + 1)-1:0]          o_entry_count,
    output logic                                  o_is_empty,
    output logic signed [31:0]                    o_front_value,
    output logic signed [31:0]                    o_back_value
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_b;

    logic [2:0]    r_kind;
    logic [31:0]   r_value;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    t_status       r_status;
    logic          r_pop_ok;
    logic [31:0]   r_popped;
    logic          r_out_valid;

    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;
    t_status       n_status;
    logic          n_pop_ok;
    logic          we;
    logic [AW-1:0] wa;
    logic [AW-1:0] ra_a;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_addr;
    logic [AW-1:0] back_addr;
    logic          is_full;
    logic          is_empty;

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return t[AW-1:0];
    endfunction

    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_addr = wrap(SW'(r_head) + SW'(r_count));
    assign back_addr = wrap(SW'(r_head) + SW'(r_count) - 1'b1);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        n_pop_ok = 1'b0;
        we       = 1'b0;
        wa       = tail_addr;
        ra_a     = r_head;
        unique case (r_kind) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    we      = i_cmd.exec;
                    n_count = r_count + 1'b1;
                    if (r_kind == KIND_PUSH_FRONT) begin
                        wa     = head_dec;
                        n_head = head_dec;
                    end
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (is_empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_pop_ok = 1'b1;
                    n_count  = r_count - 1'b1;
                    if (r_kind == KIND_POP_FRONT) begin
                        n_head = head_inc;
                    end else begin
                        ra_a = back_addr;
                    end
                end
            end
            default: n_status = ST_OK;
        endcase
        if (i_cmd.peek) begin
            ra_a = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= r_value;
        end
        if (i_cmd.exec || i_cmd.peek) begin
            r_rd_a <= r_mem[ra_a];
        end
        if (i_cmd.peek) begin
            r_rd_b <= r_mem[back_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
        if (i_cmd.peek) begin
            r_popped <= r_pop_ok ? r_rd_a : '0;
        end
        if (i_cmd.load_out) begin
            o_popped_value <= r_popped;
            o_status       <= r_status;
            o_entry_count  <= r_count;
            o_is_empty     <= is_empty;
            o_front_value  <= is_empty ? '0 : r_rd_a;
            o_back_value   <= is_empty ? '0 : r_rd_b;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sts.out_free = !r_out_valid || !i_stall;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("word count beyond depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < AW'(DEPTH - 1) || r_head == AW'(DEPTH - 1))
        else $error("head index out of range");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
            || r_count == $past(r_count) - 1'b1))
        else $error("count moved by more than one");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

endmodule

[hdl/double_ended_queue.sv]
// Double-ended queue of signed 32-bit words held in a circular buffer.
// Each input transaction carries a kind (push front, push back, pop front,
// pop back, peek; unused codes act as peek) and a word for pushes.
// Every input transaction yields exactly one output transaction: the popped
// word (zero if none), a status (ok, pop on empty, push on full dropped),
// the word count, an empty flag, and the front and back words (zero when
// empty). A pop on empty or a push on full leaves the queue unchanged.
// Both channels use valid and stall; a transaction moves on a clock edge
// with valid high and stall low.
// One transaction is in flight at a time: once the input is accepted, the
// block runs the single memory access sequence (update, read front and back,
// load the result register) before it takes the next input. The result
// register holds while the receiver stalls; the next input is taken while it
// waits, and its result is held back until the register frees.
// Reset (synchronous, active low) empties the queue and clears valid; the
// memory contents are not cleared and never show through.
// Depends on deq_pkg, deq_ctrl, deq_dp.
module double_ended_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [2:0]                            i_kind,
    input  logic signed [31:0]                    i_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [31:0]                    o_popped_value,
    output deq_pkg::t_status                      o_status,
    output logic [$clog2(DEPTH + 1)-1:0]          o_entry_count,
    output logic                                  o_is_empty,
    output logic signed [31:0]                    o_front_value,
    output logic signed [31:0]                    o_back_value
);
    import deq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

endmodule

[bench/tb_double_ended_queue.sv]
// self-checking testbench for double_ended_queue: a scoreboard class keeps a
// circular-buffer copy of the deque and predicts one result per transaction
// depends on deq_pkg and double_ended_queue
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int DEPTH = 1024;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_B = 3'd6;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;

    typedef struct {
        logic [31:0] popped;
        t_status     status;
        logic [31:0] count;
        logic        empty;
        logic [31:0] front;
        logic [31:0] back;
    } deq_result_t;

    class deque_scoreboard #(int N = 1024);
        deq_result_t pending[$];
        logic [31:0] words[N];
        int          head;
        int          held;
        int          errors;

        function new();
            head = 0;
            held = 0;
            errors = 0;
        endfunction

        function void note_request(logic [2:0] kind, logic [31:0] value);
            deq_result_t r;
            r = '{popped: '0, status: ST_OK, count: '0, empty: 1'b0, front: '0, back: '0};
            case (kind) inside
                KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                    if (held >= N) begin
                        r.status = ST_PUSH_FULL;
                    end else begin
                        if (kind == KIND_PUSH_FRONT) begin
                            head = (head + N - 1) % N;
                            words[head] = value;
                        end else begin
                            words[(head + held) % N] = value;
                        end
                        held++;
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK: begin
                    if (held == 0) begin
                        r.status = ST_POP_EMPTY;
                    end else begin
                        if (kind == KIND_POP_FRONT) begin
                            r.popped = words[head];
                            head = (head + 1) % N;
                        end else begin
                            r.popped = words[(head + held - 1) % N];
                        end
                        held--;
                    end
                end
                default: ;
            endcase
            r.count = held;
            r.empty = (held == 0);
            if (held != 0) begin
                r.front = words[head];
                r.back = words[(head + held - 1) % N];
            end
            pending.insert(pending.size(), r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] popped, t_status status, logic [31:0] count,
                                   logic empty, logic [31:0] front, logic [31:0] back);
            deq_result_t r;
            if (pending.size() == 0) begin
                $error("result transaction with no expectation waiting");
                errors++;
                return;
            end
            r = pending[0];
            pending.delete(0);
            compare_field("popped_value", r.popped, popped);
            compare_field("status", 32'(r.status), 32'(status));
            compare_field("entry_count", r.count, count);
            compare_field("is_empty", 32'(r.empty), 32'(empty));
            compare_field("front_value", r.front, front);
            compare_field("back_value", r.back, back);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_kind;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_popped_value;
    t_status            o_status;
    logic [CNT_W-1:0]   o_entry_count;
    logic               o_is_empty;
    logic signed [31:0] o_front_value;
    logic signed [31:0] o_back_value;

    deque_scoreboard #(DEPTH) sb;
    bit quiet = 1'b0;
    int rx_hold = 0;

    double_ended_queue #(.DEPTH(DEPTH)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_kind(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        if (roll < push_pct + pop_pct)
            return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
        return 3'($urandom_range(KIND_PEEK, KIND_SPARE_C));
    endfunction

    task automatic send_item(input logic [2:0] kind, input logic [31:0] value, input bit no_gap);
        int gap;
        gap = (no_gap || quiet) ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(kind, value);
    endtask

    task automatic run_mix(input int count, input int push_pct, input int pop_pct,
                           input bit no_gap);
        repeat (count) send_item(pick_kind(push_pct, pop_pct), pick_word(), no_gap);
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall before each result, or a long hold on request
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold != 0) begin
                gap = rx_hold;
                rx_hold = 0;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 9);
            end
            @(negedge i_clk);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            sb.check_result(o_popped_value, o_status, 32'(o_entry_count), o_is_empty,
                            o_front_value, o_back_value);
        end
    end

    initial begin
        #(LIMIT_CYCLES * 20);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_kind = KIND_PEEK;
        i_value = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: peeks, pops on empty, spare kind codes
        send_item(KIND_PEEK, 32'h0, 1'b0);
        send_item(KIND_POP_FRONT, 32'hdead_beef, 1'b0);
        send_item(KIND_POP_BACK, 32'h1234_5678, 1'b0);
        send_item(KIND_SPARE_A, 32'h5555_5555, 1'b0);
        send_item(KIND_SPARE_B, 32'haaaa_aaaa, 1'b0);
        send_item(KIND_SPARE_C, 32'hffff_ffff, 1'b0);
        // front push from empty wraps the head index
        send_item(KIND_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
        send_item(KIND_PUSH_BACK, 32'h8000_0000, 1'b0);
        send_item(KIND_PUSH_FRONT, 32'hffff_ffff, 1'b0);
        send_item(KIND_PUSH_BACK, 32'h0000_0000, 1'b0);
        send_item(KIND_PEEK, 32'h0f0f_0f0f, 1'b0);
        send_item(KIND_SPARE_B, 32'h0, 1'b0);
        send_item(KIND_POP_BACK, 32'h0, 1'b0);
        send_item(KIND_POP_FRONT, 32'h0, 1'b0);
        send_item(KIND_PUSH_BACK, 32'h0000_0001, 1'b0);
        send_item(KIND_POP_FRONT, 32'h0, 1'b0);
        send_item(KIND_POP_BACK, 32'h0, 1'b0);
        send_item(KIND_POP_FRONT, 32'h0, 1'b0);
        send_item(KIND_POP_BACK, 32'h0, 1'b0);
        send_item(KIND_PUSH_BACK, 32'h8000_0000, 1'b0);
        send_item(KIND_POP_FRONT, 32'h0, 1'b0);
        pause_until_drained();

        run_mix(20, 40, 40, 1'b0);

        // long receiver hold while the sender keeps offering
        rx_hold = 300;
        run_mix(25, 50, 30, 1'b1);
        pause_until_drained();

        quiet = 1'b1;
        run_mix(15, 45, 35, 1'b0);
        quiet = 1'b0;

        // fill to capacity, churn at full, then pop some back out
        while (sb.held < DEPTH) send_item(pick_kind(100, 0), pick_word(), 1'b0);
        run_mix(15, 60, 20, 1'b0);
        run_mix(10, 20, 70, 1'b0);

        pause_until_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
